// ----- design/bfsa_pkg.sv -----
// Package for the best-fit segment allocator: widths, codes, entry and state types.
// No dependencies.
package bfsa_pkg;

    localparam int MaxSeg   = 16;
    localparam int MemUnits = 32;
    localparam int IdxW     = 4;
    localparam int CntW     = 5;

    typedef enum logic [2:0] {
        CMD_ALLOC   = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_FREE    = 3'd2,
        CMD_READSEG = 3'd3,
        CMD_READMAP = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_BAD        = 3'd4
    } status_t;

    typedef struct packed {
        logic       owned;
        logic [7:0] owner;
        logic [4:0] start;
        logic [5:0] length;
    } seg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_FIND,
        S_MERGE,
        S_COMPACT,
        S_SUM,
        S_DONE
    } state_t;

    function automatic seg_t init_seg(input logic [IdxW-1:0] i);
        seg_t s;
        s = '0;
        case (i)
            4'd0: begin s.start = 5'd0;  s.length = 6'd2;  end
            4'd1: begin s.start = 5'd2;  s.length = 6'd2;  end
            4'd2: begin s.start = 5'd4;  s.length = 6'd4;  end
            4'd3: begin s.start = 5'd8;  s.length = 6'd4;  end
            4'd4: begin s.start = 5'd12; s.length = 6'd10; end
            4'd5: begin s.start = 5'd22; s.length = 6'd3;  end
            4'd6: begin s.start = 5'd25; s.length = 6'd3;  end
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ----- design/best_fit_segment_allocator_top.sv -----
// Top level of the best-fit segment allocator: stream ports and result register.
// Depends on bfsa_pkg, bfsa_seq, bfsa_busy_map.
//
// One command enters on the s_ channel; one result leaves on the m_ channel.
// s_tready is high only while the sequencer is idle and the result register
// is empty, so one command is worked on at a time.
// Release and allocate walk the segment table one entry a cycle on a
// shared compare/add unit; the free total is summed one entry a cycle.
// The time a command takes grows with the live segment count (at most 16).
// After reset the table holds seven holes, the busy map is clear and the
// output is empty. If the receiver stalls, the result holds in m_tdata and
// no new command is taken until it is accepted.
module best_fit_segment_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], owner_id[10:3], request_size[16:11], entry_index[20:17]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], alloc_start[7:3], free_total[13:8], seg_valid[14],
    // seg_owned[15], seg_owner[23:16], seg_start[28:24], seg_length[34:29],
    // map_word[66:35]
    output logic [71:0] m_tdata
);
    logic idle, done, rd_valid, map_upd, map_busy, start_cmd;
    logic [2:0] status;
    logic [4:0] alloc_start, map_start;
    logic [5:0] free_total, map_len;
    logic [31:0] map_word;
    bfsa_pkg::seg_t rd_seg;
    logic [2:0] cmd_reg;
    logic [3:0] idx_reg;
    logic m_valid_reg;
    logic [71:0] m_data_reg;
    bfsa_pkg::seg_t sv;
    logic [31:0] mw;

    assign s_tready  = idle && !m_valid_reg;
    assign start_cmd = s_tvalid && s_tready;

    bfsa_seq u_seq (
        .aclk, .aresetn, .start_cmd,
        .command(s_tdata[2:0]), .owner_id(s_tdata[10:3]),
        .request_size(s_tdata[16:11]), .entry_index(s_tdata[20:17]),
        .idle, .done, .status, .alloc_start, .free_total, .rd_seg, .rd_valid,
        .map_upd, .map_busy, .map_start, .map_len
    );

    bfsa_busy_map u_map (
        .aclk, .aresetn, .upd(map_upd), .busy(map_busy),
        .start(map_start), .length(map_len), .map_word
    );

    always_comb begin
        sv = rd_valid ? rd_seg : '0;
        mw = (cmd_reg == bfsa_pkg::CMD_READMAP && idx_reg == 4'd0) ? map_word : '0;
    end

    always_ff @(posedge aclk) begin
        if (start_cmd) begin
            cmd_reg <= s_tdata[2:0];
            idx_reg <= s_tdata[20:17];
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (done) begin
            m_data_reg <= {5'd0, mw, sv.length, sv.start, sv.owner, sv.owned,
                           rd_valid, free_total, alloc_start, status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule

// ----- design/bfsa_busy_map.sv -----
// Busy map of the segment allocator: one bit per unit, range set or clear.
// Depends on bfsa_pkg.
module bfsa_busy_map (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        upd,
    input  logic        busy,
    input  logic [4:0]  start,
    input  logic [5:0]  length,
    output logic [31:0] map_word
);
    logic [31:0] map_reg;
    logic [31:0] mask;
    logic [6:0]  lim;

    always_comb begin
        lim = 7'(start) + 7'(length);
        for (int u = 0; u < bfsa_pkg::MemUnits; u++) begin
            mask[u] = (7'(u) >= 7'(start)) && (7'(u) < lim);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg <= '0;
        end else if (upd) begin
            map_reg <= busy ? (map_reg | mask) : (map_reg & ~mask);
        end
    end

    assign map_word = map_reg;
endmodule

// ----- design/bfsa_seq.sv -----
// Segment table and sequencer: one entry per cycle through a shared compare/adder.
// Depends on bfsa_pkg.
module bfsa_seq (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start_cmd,
    input  logic [2:0]  command,
    input  logic [7:0]  owner_id,
    input  logic [5:0]  request_size,
    input  logic [3:0]  entry_index,
    output logic        idle,
    output logic        done,
    output logic [2:0]  status,
    output logic [4:0]  alloc_start,
    output logic [5:0]  free_total,
    output bfsa_pkg::seg_t rd_seg,
    output logic        rd_valid,
    output logic        map_upd,
    output logic        map_busy,
    output logic [4:0]  map_start,
    output logic [5:0]  map_len
);
    bfsa_pkg::state_t state_reg, state_next;
    bfsa_pkg::seg_t   tab_reg [bfsa_pkg::MaxSeg];
    logic [bfsa_pkg::CntW-1:0] cnt_reg, cnt_next;
    logic [bfsa_pkg::CntW-1:0] i_reg, i_next;
    logic [bfsa_pkg::CntW-1:0] best_reg, best_next;
    logic       found_reg, found_next;
    logic [5:0] sum_reg, sum_next;
    logic [2:0] st_reg, st_next;
    logic [4:0] as_reg, as_next;
    logic [2:0] cmd_reg;
    logic [7:0] own_reg;
    logic [5:0] sz_reg;
    logic [3:0] idx_reg;

    bfsa_pkg::seg_t cur, nxt, bst;
    logic [bfsa_pkg::IdxW-1:0] ci, ci1, bi;
    logic          wr_en;
    logic [bfsa_pkg::IdxW-1:0] wr_a;
    bfsa_pkg::seg_t wr_d;
    logic          wr2_en;
    logic [bfsa_pkg::IdxW-1:0] wr2_a;
    bfsa_pkg::seg_t wr2_d;

    assign ci  = i_reg[bfsa_pkg::IdxW-1:0];
    assign ci1 = ci + 1'b1;
    assign bi  = best_reg[bfsa_pkg::IdxW-1:0];
    assign cur = tab_reg[ci];
    assign nxt = tab_reg[ci1];
    assign bst = tab_reg[bi];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfsa_pkg::S_IDLE;
            cnt_reg   <= 5'd7;
            for (int k = 0; k < bfsa_pkg::MaxSeg; k++) begin
                tab_reg[k] <= bfsa_pkg::init_seg(bfsa_pkg::IdxW'(k));
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (wr_en)  tab_reg[wr_a]  <= wr_d;
            if (wr2_en) tab_reg[wr2_a] <= wr2_d;
        end
        i_reg <= i_next; best_reg <= best_next; found_reg <= found_next;
        sum_reg <= sum_next; st_reg <= st_next; as_reg <= as_next;
        if (start_cmd) begin
            cmd_reg <= command; own_reg <= owner_id;
            sz_reg <= request_size; idx_reg <= entry_index;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg; i_next = i_reg; best_next = best_reg;
        found_next = found_reg; sum_next = sum_reg; st_next = st_reg;
        as_next = as_reg;
        wr_en = 1'b0; wr_a = ci; wr_d = cur;
        wr2_en = 1'b0; wr2_a = ci; wr2_d = cur;
        map_upd = 1'b0; map_busy = 1'b0; map_start = cur.start; map_len = cur.length;
        case (state_reg)
            bfsa_pkg::S_IDLE: begin
                i_next = '0; found_next = 1'b0; best_next = '0;
                sum_next = '0; as_next = '0; st_next = bfsa_pkg::ST_OK;
                if (start_cmd) begin
                    case (command)
                        bfsa_pkg::CMD_ALLOC: begin
                            if (request_size == 6'd0) begin
                                st_next = bfsa_pkg::ST_BAD;
                                state_next = bfsa_pkg::S_SUM;
                            end else begin
                                state_next = bfsa_pkg::S_SCAN;
                            end
                        end
                        bfsa_pkg::CMD_RELEASE: state_next = bfsa_pkg::S_FIND;
                        bfsa_pkg::CMD_FREE, bfsa_pkg::CMD_READSEG,
                        bfsa_pkg::CMD_READMAP: state_next = bfsa_pkg::S_SUM;
                        default: begin
                            st_next = bfsa_pkg::ST_BAD;
                            state_next = bfsa_pkg::S_SUM;
                        end
                    endcase
                end
            end
            bfsa_pkg::S_SCAN: begin
                if (i_reg >= cnt_reg) begin
                    i_next = '0;
                    if (!found_reg) begin
                        st_next = bfsa_pkg::ST_NO_SPACE;
                        state_next = bfsa_pkg::S_SUM;
                    end else if (bst.length != sz_reg) begin
                        if (cnt_reg >= 5'(bfsa_pkg::MaxSeg)) begin
                            st_next = bfsa_pkg::ST_TABLE_FULL;
                            state_next = bfsa_pkg::S_SUM;
                        end else begin
                            i_next = cnt_reg;
                            state_next = bfsa_pkg::S_SHIFT;
                        end
                    end else begin
                        state_next = bfsa_pkg::S_PLACE;
                    end
                end else begin
                    if (!cur.owned && cur.length >= sz_reg &&
                        (!found_reg || cur.length < bst.length)) begin
                        best_next = i_reg; found_next = 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            bfsa_pkg::S_SHIFT: begin
                // move slot i-1 to i, down to best+1
                if (i_reg == best_reg + 1'b1) begin
                    wr_en = 1'b1; wr_a = ci;
                    wr_d = '0;
                    wr_d.start  = bst.start + sz_reg[4:0];
                    wr_d.length = bst.length - sz_reg;
                    cnt_next = cnt_reg + 1'b1;
                    i_next = '0;
                    state_next = bfsa_pkg::S_PLACE;
                end else begin
                    wr_en = 1'b1; wr_a = ci; wr_d = tab_reg[ci - 1'b1];
                    i_next = i_reg - 1'b1;
                end
            end
            bfsa_pkg::S_PLACE: begin
                wr_en = 1'b1; wr_a = bi;
                wr_d = bst; wr_d.owned = 1'b1; wr_d.owner = own_reg; wr_d.length = sz_reg;
                map_upd = 1'b1; map_busy = 1'b1;
                map_start = bst.start; map_len = sz_reg;
                as_next = bst.start;
                i_next = '0;
                state_next = bfsa_pkg::S_SUM;
            end
            bfsa_pkg::S_FIND: begin
                if (i_reg >= cnt_reg) begin
                    st_next = bfsa_pkg::ST_NOT_FOUND;
                    i_next = '0;
                    state_next = bfsa_pkg::S_SUM;
                end else if (cur.owned && cur.owner == own_reg) begin
                    wr_en = 1'b1; wr_a = ci;
                    wr_d = cur; wr_d.owned = 1'b0; wr_d.owner = '0;
                    map_upd = 1'b1; map_busy = 1'b0;
                    i_next = '0;
                    state_next = bfsa_pkg::S_MERGE;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            bfsa_pkg::S_MERGE: begin
                if (i_reg + 1'b1 >= cnt_reg) begin
                    i_next = '0;
                    state_next = bfsa_pkg::S_SUM;
                end else if (!cur.owned && !nxt.owned) begin
                    wr_en = 1'b1; wr_a = ci;
                    wr_d = cur; wr_d.length = cur.length + nxt.length;
                    best_next = i_reg;
                    i_next = i_reg + 1'b1;
                    state_next = bfsa_pkg::S_COMPACT;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            bfsa_pkg::S_COMPACT: begin
                // close the gap at slot i by pulling later slots down
                if (i_reg + 1'b1 >= cnt_reg) begin
                    cnt_next = cnt_reg - 1'b1;
                    i_next = best_reg;
                    state_next = bfsa_pkg::S_MERGE;
                end else begin
                    wr2_en = 1'b1; wr2_a = ci; wr2_d = nxt;
                    i_next = i_reg + 1'b1;
                end
            end
            bfsa_pkg::S_SUM: begin
                if (i_reg >= cnt_reg) begin
                    state_next = bfsa_pkg::S_DONE;
                end else begin
                    if (!cur.owned) sum_next = sum_reg + cur.length;
                    i_next = i_reg + 1'b1;
                end
            end
            bfsa_pkg::S_DONE: state_next = bfsa_pkg::S_IDLE;
            default: state_next = bfsa_pkg::S_IDLE;
        endcase
    end

    assign idle        = (state_reg == bfsa_pkg::S_IDLE);
    assign done        = (state_reg == bfsa_pkg::S_DONE);
    assign status      = st_reg;
    assign alloc_start = as_reg;
    assign free_total  = sum_reg;
    assign rd_valid    = (cmd_reg == bfsa_pkg::CMD_READSEG) && (5'(idx_reg) < cnt_reg);
    assign rd_seg      = tab_reg[idx_reg];
endmodule
